// ----- sv/skoi_pkg.sv -----
// ----------------------------------------------------------------------------
// skoi_pkg
// Types, opcode constants and helper functions shared by the seed-to-key
// instruction interpreter.
// ----------------------------------------------------------------------------
package skoi_pkg;

    // One instruction item as it is held in the input register.
    typedef struct packed {
        logic        first_step;
        logic [15:0] seed;
        logic        invert_only;
        logic [7:0]  opcode;
        logic [7:0]  operand_a;
        logic [7:0]  operand_b;
        logic        last_step;
    } skoi_instr_t;

    // Opcodes of the instruction set.
    localparam logic [7:0] OP_SWAP      = 8'h05;
    localparam logic [7:0] OP_ADD_AB    = 8'h14;
    localparam logic [7:0] OP_NOT_INC   = 8'h2A;
    localparam logic [7:0] OP_AND_BA    = 8'h37;
    localparam logic [7:0] OP_ROTL      = 8'h4C;
    localparam logic [7:0] OP_OR_BA     = 8'h52;
    localparam logic [7:0] OP_ROTR      = 8'h6B;
    localparam logic [7:0] OP_ADD_BA    = 8'h75;
    localparam logic [7:0] OP_SWAP_ADD  = 8'h7E;
    localparam logic [7:0] OP_SUB_AB    = 8'h98;
    localparam logic [7:0] OP_SUB_BA    = 8'hF8;

    // Exchange the two bytes of a word.
    function automatic logic [15:0] swap_bytes(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // Rotate left by the low four bits of the amount.
    function automatic logic [15:0] rotate_left(input logic [15:0] v,
                                                input logic [3:0]  n);
        logic [31:0] t;
        t = {v, v} << n;
        return t[31:16];
    endfunction

    // Rotate right by the low four bits of the amount.
    function automatic logic [15:0] rotate_right(input logic [15:0] v,
                                                 input logic [3:0]  n);
        logic [31:0] t;
        t = {v, v} >> n;
        return t[15:0];
    endfunction

endpackage

// ----- sv/skoi_alu.sv -----
// ----------------------------------------------------------------------------
// skoi_alu
// Combinational instruction unit: computes the next running value from the
// current one and one instruction item.
// ----------------------------------------------------------------------------
module skoi_alu
    import skoi_pkg::*;
(
    input  logic [15:0] value,
    input  skoi_instr_t instr,
    output logic [15:0] value_next
);

    logic [15:0] base;
    logic [15:0] word_ab;
    logic [15:0] word_ba;
    logic [15:0] swapped;
    logic [15:0] result;

    // Operand words in both byte orders.
    assign word_ab = {instr.operand_a, instr.operand_b};
    assign word_ba = {instr.operand_b, instr.operand_a};

    // The first instruction of a sequence works on the seed.
    assign base    = instr.first_step ? instr.seed : value;
    assign swapped = swap_bytes(base);

    // Opcode decode; unknown opcodes pass the base value (seed or running value) through.
    always_comb begin
        case (instr.opcode)
            OP_SWAP:     result = swapped;
            OP_ADD_AB:   result = base + word_ab;
            OP_NOT_INC:  result = ~base + {15'd0, (instr.operand_a < instr.operand_b)};
            OP_AND_BA:   result = base & word_ba;
            OP_ROTL:     result = rotate_left(base, instr.operand_a[3:0]);
            OP_OR_BA:    result = base | word_ba;
            OP_ROTR:     result = rotate_right(base, instr.operand_b[3:0]);
            OP_ADD_BA:   result = base + word_ba;
            OP_SWAP_ADD: begin
                result = swapped + ((instr.operand_a >= instr.operand_b) ? word_ab : word_ba);
            end
            OP_SUB_AB:   result = base - word_ab;
            OP_SUB_BA:   result = base - word_ba;
            default:     result = base;
        endcase
    end

    // Algorithm zero overrides the instruction with the complemented seed.
    assign value_next = instr.invert_only ? ~instr.seed : result;

endmodule

// ----- sv/skoi_out_stage.sv -----
// ----------------------------------------------------------------------------
// skoi_out_stage
// Result register: holds one key item until the downstream side takes it.
// ----------------------------------------------------------------------------
module skoi_out_stage (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [15:0] key_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_key
);

    logic        vld_reg;
    logic        vld_next;
    logic [15:0] key_reg;

    // A load only happens when the register is empty or being emptied.
    assign vld_next = load | (vld_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Key payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            key_reg <= key_in;
        end
    end

    assign m_valid = vld_reg;
    assign m_key   = key_reg;

endmodule

// ----- sv/seed_key_opcode_interpreter.sv -----
// Flow: the last instruction is held in the input register until the result register can take its
// key; the key is then loaded into the result register, which raises m_valid.
// Throughput: one instruction item per cycle, but a last instruction waits while the result register
// holds an untaken key; the running value loop closes through the instruction unit and the running value register.
// Reset: synchronous active-low aresetn empties the input and result registers and
// clears the running value to zero.
// ----------------------------------------------------------------------------
// seed_key_opcode_interpreter
// Seed-to-key instruction interpreter: applies one instruction item per cycle (a last
// instruction waits while a key is untaken) to a 16-bit running value and emits the key after the last instruction.
// ----------------------------------------------------------------------------
module seed_key_opcode_interpreter
    import skoi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first_step,
    input  logic [15:0] s_seed,
    input  logic        s_invert_only,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_operand_a,
    input  logic [7:0]  s_operand_b,
    input  logic        s_last_step,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_key
);

    skoi_instr_t instr_reg;
    logic        in_vld_reg;
    logic        in_vld_next;
    logic [15:0] value_reg;
    logic [15:0] value_next;
    logic        advance;
    logic        load_key;
    logic        s_accept;

    // The held item moves on unless it carries a key and the result slot is blocked.
    assign advance  = in_vld_reg & (~instr_reg.last_step | ~m_valid | m_ready);
    assign load_key = advance & instr_reg.last_step;
    assign s_ready  = ~in_vld_reg | advance;
    assign s_accept = s_valid & s_ready;

    assign in_vld_next = s_accept | (in_vld_reg & ~advance);

    // Input register control and the running value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            value_reg  <= 16'd0;
        end else begin
            in_vld_reg <= in_vld_next;
            if (advance) begin
                value_reg <= value_next;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            instr_reg.first_step  <= s_first_step;
            instr_reg.seed        <= s_seed;
            instr_reg.invert_only <= s_invert_only;
            instr_reg.opcode      <= s_opcode;
            instr_reg.operand_a   <= s_operand_a;
            instr_reg.operand_b   <= s_operand_b;
            instr_reg.last_step   <= s_last_step;
        end
    end

    // Instruction unit.
    skoi_alu u_alu (
        .value      (value_reg),
        .instr      (instr_reg),
        .value_next (value_next)
    );

    // Result register.
    skoi_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load_key),
        .key_in  (value_next),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_key   (m_key)
    );

endmodule

// ----- sv/skoi_checker.sv -----
// ----------------------------------------------------------------------------
// skoi_port_checks
// Port-level checks on the seed-to-key interpreter, bound to the top level.
// ----------------------------------------------------------------------------
module skoi_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [15:0] s_seed,
    input logic        s_invert_only,
    input logic        s_last_step,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_key
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled key item holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key))
        else $error("stalled key item changed or dropped");

    // A fresh key item must be preceded by an accepted last instruction.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_step, 2))
        else $error("key item without a last instruction");

    // Algorithm zero gives the complemented seed when the result slot is free.
    a_invert_key: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_invert_only && s_last_step ##1 (!m_valid || m_ready)
        |=> m_valid && (m_key == ~$past(s_seed, 2)))
        else $error("wrong key for algorithm zero");

endmodule

bind seed_key_opcode_interpreter skoi_port_checks u_skoi_port_checks (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_seed        (s_seed),
    .s_invert_only (s_invert_only),
    .s_last_step   (s_last_step),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_key         (m_key)
);
